/* hw/rtl/ipv6at_pkg.sv */
// ---------------------------------------------------------------------------
// ipv6at_pkg
// Shared types and constants for the interface address table: operation
// codes, address constants and the request token that runs along the cells.
// ---------------------------------------------------------------------------
`default_nettype none

package ipv6at_pkg;

  localparam int unsigned ENTRIES_DEF = 8;
  localparam int unsigned ADDR_BYTES  = 16;
  localparam int unsigned CP_W        = $clog2(ADDR_BYTES + 1);

  typedef logic [2:0] opcode_t;

  localparam opcode_t OP_WRITE   = 3'd0;
  localparam opcode_t OP_IS_SELF = 3'd1;
  localparam opcode_t OP_SOL     = 3'd2;
  localparam opcode_t OP_NSOL    = 3'd3;
  localparam opcode_t OP_RSOL    = 3'd4;
  localparam opcode_t OP_LOOKUP  = 3'd5;

  localparam logic [7:0] MCAST_BYTE     = 8'hff;
  localparam logic [9:0] LINK_LOCAL_PFX = 10'h3fa;

  // Request plus the running answer, handed from cell to cell
  typedef struct packed {
    opcode_t           op;
    logic [2:0]        wr_idx;
    logic              wr_used;
    logic [63:0]       addr_high;
    logic [63:0]       addr_low;
    logic [63:0]       sol_high;
    logic [63:0]       sol_low;
    logic              search;
    logic              hit;
    logic [2:0]        idx;
    logic [CP_W-1:0]   best_cp;
    logic              link_local;
    logic [63:0]       src_high;
    logic [63:0]       src_low;
  } token_t;

endpackage

`default_nettype wire

/* hw/rtl/ipv6at_cfg_if.sv */
// ---------------------------------------------------------------------------
// ipv6at_cfg_if
// Configuration write channel: loopback flag.
// ---------------------------------------------------------------------------
`default_nettype none

interface ipv6at_cfg_if;
  logic valid;
  logic ready;
  logic loopback_interface;

  modport source (output valid, output loopback_interface, input ready);
  modport sink   (input valid, input loopback_interface, output ready);
endinterface

`default_nettype wire

/* hw/rtl/ipv6at_req_if.sv */
// ---------------------------------------------------------------------------
// ipv6at_req_if
// Request channel: one table operation per request.
// ---------------------------------------------------------------------------
`default_nettype none

interface ipv6at_req_if;
  logic        valid;
  logic        ready;
  logic [2:0]  opcode;
  logic [2:0]  entry_index;
  logic        entry_valid;
  logic [63:0] addr_high;
  logic [63:0] addr_low;
  logic [63:0] solicited_high;
  logic [63:0] solicited_low;
  logic        no_unicast_l3;

  modport source (output valid, output opcode, output entry_index, output entry_valid,
                  output addr_high, output addr_low, output solicited_high,
                  output solicited_low, output no_unicast_l3, input ready);
  modport sink   (input valid, input opcode, input entry_index, input entry_valid,
                  input addr_high, input addr_low, input solicited_high,
                  input solicited_low, input no_unicast_l3, output ready);
endinterface

`default_nettype wire

/* hw/rtl/ipv6at_rsp_if.sv */
// ---------------------------------------------------------------------------
// ipv6at_rsp_if
// Response channel: one answer per request.
// ---------------------------------------------------------------------------
`default_nettype none

interface ipv6at_rsp_if;
  logic        valid;
  logic        ready;
  logic        found;
  logic [2:0]  match_index;
  logic [63:0] source_high;
  logic [63:0] source_low;

  modport source (output valid, output found, output match_index, output source_high,
                  output source_low, input ready);
  modport sink   (input valid, input found, input match_index, input source_high,
                  input source_low, output ready);
endinterface

`default_nettype wire

/* hw/rtl/ipv6at_cell.sv */
// ---------------------------------------------------------------------------
// ipv6at_cell
// One table entry. Stores a write aimed at it and folds its entry into the
// running answer of a passing query, then hands the token on.
// ---------------------------------------------------------------------------
`default_nettype none

module ipv6at_cell import ipv6at_pkg::*; #(
  parameter int unsigned INDEX = 0
) (
  input  wire    clk_i,
  input  wire    rst_ni,
  input  wire    in_vld_i,
  input  token_t in_tok_i,
  output logic   out_vld_o,
  output token_t out_tok_o
);

  localparam logic [2:0] MyIdx    = 3'(INDEX);
  localparam bit         Writable = (INDEX < 8);

  logic        used_q;
  logic [63:0] uni_high_q, uni_low_q, mc_high_q, mc_low_q;
  logic        out_vld_q;
  token_t      out_tok_q;
  token_t      tok_d;
  logic        wr_en;
  logic        uni_eq, mc_eq;
  logic [ADDR_BYTES-1:0] byte_eq;
  logic [CP_W-1:0]       cp;
  logic [127:0] uni_addr, qry_addr;

  assign wr_en = in_vld_i && (in_tok_i.op == OP_WRITE) && Writable
                 && (in_tok_i.wr_idx == MyIdx);

  assign uni_addr = {uni_high_q, uni_low_q};
  assign qry_addr = {in_tok_i.addr_high, in_tok_i.addr_low};
  assign uni_eq   = (uni_addr == qry_addr);
  assign mc_eq    = ({mc_high_q, mc_low_q} == qry_addr);

  // Leading run of equal bytes, byte 0 at the top
  always_comb begin
    for (int k = 0; k < ADDR_BYTES; k++) begin
      byte_eq[k] = (uni_addr[127-8*k -: 8] == qry_addr[127-8*k -: 8]);
    end
    cp = CP_W'(ADDR_BYTES);
    for (int k = ADDR_BYTES - 1; k >= 0; k--) begin
      if (!byte_eq[k]) cp = CP_W'(k);
    end
  end

  always_comb begin
    tok_d = in_tok_i;
    if (used_q) begin
      case (in_tok_i.op)
        OP_IS_SELF, OP_LOOKUP: begin
          if (in_tok_i.search && !in_tok_i.hit && uni_eq) begin
            tok_d.hit = 1'b1;
            tok_d.idx = MyIdx;
          end
        end
        OP_SOL: begin
          if (!in_tok_i.hit && mc_eq) begin
            tok_d.hit = 1'b1;
            tok_d.idx = MyIdx;
          end
        end
        OP_NSOL: begin
          if (cp > in_tok_i.best_cp) begin
            tok_d.hit      = 1'b1;
            tok_d.idx      = MyIdx;
            tok_d.best_cp  = cp;
            tok_d.src_high = uni_high_q;
            tok_d.src_low  = uni_low_q;
          end
        end
        OP_RSOL: begin
          // a link-local entry overrides an earlier fallback, then stop
          if (!in_tok_i.link_local
              && (uni_high_q[63:54] == LINK_LOCAL_PFX || !in_tok_i.hit)) begin
            tok_d.hit        = 1'b1;
            tok_d.idx        = MyIdx;
            tok_d.link_local = (uni_high_q[63:54] == LINK_LOCAL_PFX);
            tok_d.src_high   = uni_high_q;
            tok_d.src_low    = uni_low_q;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q    <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= in_vld_i;
      if (wr_en) used_q <= in_tok_i.wr_used;
    end
  end

  always_ff @(posedge clk_i) begin
    out_tok_q <= tok_d;
    if (wr_en) begin
      uni_high_q <= in_tok_i.addr_high;
      uni_low_q  <= in_tok_i.addr_low;
      mc_high_q  <= in_tok_i.sol_high;
      mc_low_q   <= in_tok_i.sol_low;
    end
  end

  assign out_vld_o = out_vld_q;
  assign out_tok_o = out_tok_q;

endmodule

`default_nettype wire

/* hw/rtl/ipv6_interface_address_table.sv */
// ---------------------------------------------------------------------------
// ipv6_interface_address_table
// Interface IPv6 address table built as a row of entry cells; each request
// walks the row one cell per cycle and collects its answer on the way.
// ---------------------------------------------------------------------------
// Flow: a request is accepted only while no other request is in the cell row;
//   the next one is taken once the finished one is loaded into the response register.
// Reset: all entries unused, loopback flag cleared, no response pending.
// ---------------------------------------------------------------------------
`default_nettype none

module ipv6_interface_address_table import ipv6at_pkg::*; #(
  parameter int unsigned ENTRIES = ENTRIES_DEF
) (
  input  wire          clk_i,
  input  wire          rst_ni,
  ipv6at_cfg_if.sink   cfg_i,
  ipv6at_req_if.sink   req_i,
  ipv6at_rsp_if.source rsp_o
);

  logic   loopback_q;
  logic   busy_q;
  logic   hold_vld_q;
  token_t hold_tok_q;
  logic   rsp_vld_q;
  token_t rsp_tok_q;

  logic   vld [ENTRIES+1];
  token_t tok [ENTRIES+1];

  logic   accept, is_mcast, out_free, load_rsp;
  logic   head_vld;
  token_t head_tok;
  token_t sel_tok;

  assign cfg_i.ready = 1'b1;
  assign req_i.ready = !busy_q;
  assign accept      = req_i.valid && !busy_q;
  assign is_mcast    = (req_i.addr_high[63:56] == MCAST_BYTE);

  // Build the request token; loopback and multicast is_self settle here
  always_comb begin
    head_tok           = '0;
    head_tok.op        = req_i.opcode;
    head_tok.wr_idx    = req_i.entry_index;
    head_tok.wr_used   = req_i.entry_valid;
    head_tok.addr_high = req_i.addr_high;
    head_tok.addr_low  = req_i.addr_low;
    head_tok.sol_high  = req_i.solicited_high;
    head_tok.sol_low   = req_i.solicited_low;
    if (req_i.opcode == OP_IS_SELF) begin
      head_tok.hit    = loopback_q || (is_mcast && req_i.addr_high[51:48] > 4'd1);
      head_tok.search = !loopback_q && !is_mcast && !req_i.no_unicast_l3;
    end else begin
      head_tok.search = 1'b1;
    end
    head_vld = accept;
  end

  assign vld[0] = head_vld;
  assign tok[0] = head_tok;

  for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
    ipv6at_cell #(.INDEX(g)) u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .in_vld_i  (vld[g]),
      .in_tok_i  (tok[g]),
      .out_vld_o (vld[g+1]),
      .out_tok_o (tok[g+1])
    );
  end

  assign out_free = !rsp_vld_q || rsp_o.ready;
  assign load_rsp = out_free && (hold_vld_q || vld[ENTRIES]);
  assign sel_tok  = hold_vld_q ? hold_tok_q : tok[ENTRIES];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      loopback_q <= 1'b0;
      busy_q     <= 1'b0;
      hold_vld_q <= 1'b0;
      rsp_vld_q  <= 1'b0;
    end else begin
      if (cfg_i.valid) loopback_q <= cfg_i.loopback_interface;
      if (accept) busy_q <= 1'b1;
      if (load_rsp) begin
        rsp_vld_q  <= 1'b1;
        busy_q     <= 1'b0;
        hold_vld_q <= 1'b0;
      end else if (out_free) begin
        rsp_vld_q <= 1'b0;
      end
      // park the finished request while the response register is full
      if (vld[ENTRIES] && !out_free) hold_vld_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (vld[ENTRIES] && !out_free) hold_tok_q <= tok[ENTRIES];
    if (load_rsp) rsp_tok_q <= sel_tok;
  end

  assign rsp_o.valid       = rsp_vld_q;
  assign rsp_o.found       = rsp_tok_q.hit;
  assign rsp_o.match_index = rsp_tok_q.idx;
  assign rsp_o.source_high = rsp_tok_q.src_high;
  assign rsp_o.source_low  = rsp_tok_q.src_low;

endmodule

`default_nettype wire

/* tb/tb_ipv6_interface_address_table.sv */
// ---------------------------------------------------------------------------
// tb_ipv6_interface_address_table
// Self-checking bench for the interface address table. Table writes and
// queries go in through the request channel; a shadow copy of the table and
// of the loopback flag predicts every answer, and the response monitor checks
// each answer field by field against the oldest prediction. Phases vary the
// loopback flag, sender gaps and receiver back-pressure, including a long
// receiver hold-off that backs the block up onto its request input.
// ---------------------------------------------------------------------------
`default_nettype none

module tb_ipv6_interface_address_table;
  import ipv6at_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned N_ENTRY     = ENTRIES_DEF;
  localparam int unsigned ITEMS_PHASE = 145;
  localparam int unsigned CYCLE_LIMIT = 300000;
  localparam int unsigned HOLD_CYCLES = 400;

  // codes outside the defined operation set
  localparam opcode_t OP_SPARE6 = 3'd6;
  localparam opcode_t OP_SPARE7 = 3'd7;

  typedef struct packed {
    opcode_t      op;
    logic [2:0]   idx;
    logic         used;
    logic [127:0] addr;
    logic [127:0] sol;
    logic         no_uni;
  } request_t;

  typedef struct packed {
    logic         found;
    logic [2:0]   idx;
    logic [127:0] src;
  } answer_t;

  logic clk_i;
  logic rst_ni = 1'b0;

  logic     req_valid = 1'b0;
  request_t req_pay   = '0;
  logic     rsp_ready = 1'b0;
  logic     cfg_valid = 1'b0;
  logic     cfg_loop  = 1'b0;

  ipv6at_cfg_if cfg_if ();
  ipv6at_req_if req_if ();
  ipv6at_rsp_if rsp_if ();

  assign cfg_if.valid              = cfg_valid;
  assign cfg_if.loopback_interface = cfg_loop;
  assign req_if.valid              = req_valid;
  assign req_if.opcode             = req_pay.op;
  assign req_if.entry_index        = req_pay.idx;
  assign req_if.entry_valid        = req_pay.used;
  assign req_if.addr_high          = req_pay.addr[127:64];
  assign req_if.addr_low           = req_pay.addr[63:0];
  assign req_if.solicited_high     = req_pay.sol[127:64];
  assign req_if.solicited_low      = req_pay.sol[63:0];
  assign req_if.no_unicast_l3      = req_pay.no_uni;
  assign rsp_if.ready              = rsp_ready;

  ipv6_interface_address_table #(.ENTRIES(N_ENTRY)) DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_if),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  // shadow table and loopback flag
  bit           shadow_used [N_ENTRY];
  logic [127:0] shadow_uni  [N_ENTRY];
  logic [127:0] shadow_sol  [N_ENTRY];
  bit           loopback_now = 1'b0;

  // what the generator has written so far, for building hits
  bit           gen_set [N_ENTRY];
  logic [127:0] gen_uni [N_ENTRY];
  logic [127:0] gen_sol [N_ENTRY];

  request_t    pending_reqs[$];
  answer_t     answers_due[$];
  int unsigned send_idle_pct = 0;
  int unsigned rsp_stall_pct = 0;
  bit          hold_go       = 1'b0;
  logic        stall_hold    = 1'b0;
  int unsigned errors        = 0;
  int unsigned cycles        = 0;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  function automatic int shared_bytes(input logic [127:0] a, input logic [127:0] b);
    int  n;
    bit  diff;
    n    = 0;
    diff = 1'b0;
    for (int k = 0; k < 16; k++) begin
      if (!diff && a[127-8*k -: 8] == b[127-8*k -: 8]) n++;
      else diff = 1'b1;
    end
    return n;
  endfunction

  function automatic int first_unicast(input logic [127:0] a);
    int pick;
    pick = -1;
    for (int i = 0; i < N_ENTRY; i++)
      if (pick < 0 && shadow_used[i] && shadow_uni[i] == a) pick = i;
    return pick;
  endfunction

  // apply one request to the shadow table and work out its answer
  function automatic answer_t table_answer(input request_t r);
    answer_t a;
    int      pick;
    int      first;
    int      best_len;
    int      len;
    a    = '0;
    pick = -1;
    case (r.op)
      OP_WRITE: begin
        shadow_used[r.idx] = r.used;
        shadow_uni[r.idx]  = r.addr;
        shadow_sol[r.idx]  = r.sol;
      end
      OP_IS_SELF: begin
        if (loopback_now) begin
          a.found = 1'b1;
        end else if (r.addr[127:120] == MCAST_BYTE) begin
          a.found = (r.addr[115:112] > 4'd1);
        end else if (!r.no_uni) begin
          pick = first_unicast(r.addr);
          if (pick >= 0) begin
            a.found = 1'b1;
            a.idx   = pick[2:0];
          end
        end
      end
      OP_SOL: begin
        for (int i = 0; i < N_ENTRY; i++)
          if (pick < 0 && shadow_used[i] && shadow_sol[i] == r.addr) pick = i;
        if (pick >= 0) begin
          a.found = 1'b1;
          a.idx   = pick[2:0];
        end
      end
      OP_NSOL: begin
        best_len = 0;
        for (int i = 0; i < N_ENTRY; i++) begin
          if (shadow_used[i]) begin
            len = shared_bytes(shadow_uni[i], r.addr);
            if (len > best_len) begin
              best_len = len;
              pick     = i;
            end
          end
        end
      end
      OP_RSOL: begin
        first = -1;
        for (int i = 0; i < N_ENTRY; i++) begin
          if (shadow_used[i]) begin
            if (first < 0) first = i;
            if (pick < 0 && shadow_uni[i][127:118] == LINK_LOCAL_PFX) pick = i;
          end
        end
        if (pick < 0) pick = first;
      end
      OP_LOOKUP: begin
        pick = first_unicast(r.addr);
        if (pick >= 0) begin
          a.found = 1'b1;
          a.idx   = pick[2:0];
        end
      end
      default: ;
    endcase
    if ((r.op == OP_NSOL || r.op == OP_RSOL) && pick >= 0) begin
      a.found = 1'b1;
      a.idx   = pick[2:0];
      a.src   = shadow_uni[pick];
    end
    return a;
  endfunction

  function automatic logic [127:0] rand_addr();
    return {$urandom, $urandom, $urandom, $urandom};
  endfunction

  function automatic logic [127:0] link_local_addr();
    logic [127:0] a;
    a = rand_addr();
    a[127:118] = LINK_LOCAL_PFX;
    if ($urandom_range(1) == 0) a[117:64] = '0;
    return a;
  endfunction

  function automatic logic [127:0] mcast_addr();
    logic [127:0] a;
    a = rand_addr();
    a[127:120] = MCAST_BYTE;
    // lean on the rejected scopes now and then
    if ($urandom_range(2) == 0) a[115:112] = 4'($urandom_range(1));
    return a;
  endfunction

  // random request, mostly aimed at addresses already in the table
  function automatic request_t random_request();
    request_t     r;
    logic [127:0] mask;
    int           j;
    int           k;
    int           kind;
    r        = '0;
    r.no_uni = ($urandom_range(3) == 0);
    j        = $urandom_range(N_ENTRY - 1);
    kind     = $urandom_range(9);
    if ($urandom_range(99) < 30) begin
      r.op   = OP_WRITE;
      r.idx  = 3'($urandom_range(N_ENTRY - 1));
      r.used = ($urandom_range(6) != 0);
      if (kind < 4) begin
        r.addr = link_local_addr();
      end else if (kind < 6 && gen_set[j]) begin
        // share a leading byte run with another entry, sometimes all of it
        k      = $urandom_range(16, 1);
        mask   = {128{1'b1}} << (8 * (16 - k));
        r.addr = (gen_uni[j] & mask) | (rand_addr() & ~mask);
      end else if (kind == 6) begin
        r.addr = mcast_addr();
      end else if (kind == 7) begin
        r.addr = ($urandom_range(1) == 0) ? '0 : '1;
      end else begin
        r.addr = rand_addr();
      end
      if ($urandom_range(2) == 0) r.sol = rand_addr();
      else r.sol = {104'hff02_0000_0000_0000_0000_0001_ff, r.addr[23:0]};
      gen_set[r.idx] = 1'b1;
      gen_uni[r.idx] = r.addr;
      gen_sol[r.idx] = r.sol;
    end else begin
      r.op   = opcode_t'($urandom_range(OP_LOOKUP, OP_IS_SELF));
      r.idx  = 3'($urandom_range(7));
      r.used = 1'($urandom_range(1));
      r.sol  = rand_addr();
      if (kind < 4 && gen_set[j]) begin
        r.addr = (r.op == OP_SOL && $urandom_range(1) == 0) ? gen_sol[j] : gen_uni[j];
      end else if (kind < 6 && gen_set[j]) begin
        k      = $urandom_range(15);
        r.addr = gen_uni[j];
        r.addr[127-8*k -: 8] = r.addr[127-8*k -: 8] ^ 8'($urandom_range(255, 1));
      end else if (kind == 6) begin
        r.addr = mcast_addr();
      end else if (kind == 7) begin
        r.addr = link_local_addr();
      end else if (kind == 8 && gen_set[j]) begin
        r.addr = gen_sol[j];
      end else begin
        r.addr = rand_addr();
      end
    end
    return r;
  endfunction

  task automatic queue_req(input opcode_t op, input int idx, input bit used,
                           input logic [127:0] addr, input logic [127:0] sol,
                           input bit no_uni);
    request_t r;
    r.op     = op;
    r.idx    = 3'(idx);
    r.used   = used;
    r.addr   = addr;
    r.sol    = sol;
    r.no_uni = no_uni;
    pending_reqs.push_back(r);
  endtask

  // hold until every request has gone in and been answered
  task automatic wait_quiet();
    while (pending_reqs.size() != 0 || req_valid || answers_due.size() != 0)
      @(negedge clk_i);
    repeat (N_ENTRY + 4) @(negedge clk_i);
  endtask

  task automatic set_loopback(input bit v);
    @(posedge clk_i);
    cfg_valid <= 1'b1;
    cfg_loop  <= v;
    do @(posedge clk_i); while (!cfg_if.ready);
    cfg_valid    <= 1'b0;
    loopback_now  = v;
  endtask

  task automatic report_error(input string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    errors++;
  endtask

  // request driver
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (req_valid && req_if.ready) answers_due.push_back(table_answer(req_pay));
      if (!req_valid || req_if.ready) begin
        if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          req_pay   <= pending_reqs.pop_front();
          req_valid <= 1'b1;
        end else begin
          req_valid <= 1'b0;
        end
      end
    end
  end

  // response monitor
  always @(posedge clk_i) begin : rsp_check
    answer_t want;
    if (rsp_ready && rsp_if.valid) begin
      if (answers_due.size() == 0) begin
        report_error("response with no request outstanding");
      end else begin
        want = answers_due.pop_front();
        if (rsp_if.found !== want.found)
          report_error($sformatf("found %b, want %b", rsp_if.found, want.found));
        if (rsp_if.match_index !== want.idx)
          report_error($sformatf("match_index %0d, want %0d", rsp_if.match_index, want.idx));
        if (rsp_if.source_high !== want.src[127:64])
          report_error($sformatf("source_high %h, want %h",
                                 rsp_if.source_high, want.src[127:64]));
        if (rsp_if.source_low !== want.src[63:0])
          report_error($sformatf("source_low %h, want %h",
                                 rsp_if.source_low, want.src[63:0]));
      end
    end
    if (!rst_ni) rsp_ready <= 1'b0;
    else rsp_ready <= !stall_hold && ($urandom_range(99) >= rsp_stall_pct);
  end

  // long receiver hold-off, started once by the stimulus
  initial begin
    wait (hold_go);
    stall_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk_i);
    stall_hold <= 1'b0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin : stimulus
    logic [127:0] gua;
    logic [127:0] lla;
    logic [127:0] ones;
    gua  = 128'h2001_0db8_0000_0000_0000_0000_0000_0001;
    lla  = 128'hfe80_0000_0000_0000_0000_0000_0000_00aa;
    ones = '1;

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    set_loopback(1'b0);

    // empty table: nothing to find
    queue_req(OP_RSOL,    0, 0, '0, '0, 0);
    queue_req(OP_NSOL,    0, 0, gua, '0, 0);
    queue_req(OP_LOOKUP,  0, 0, '0, '0, 0);
    queue_req(OP_IS_SELF, 0, 0, '0, '0, 0);
    // fill a few entries, one of them unused
    queue_req(OP_WRITE, 0, 1, gua, {104'hff02_0000_0000_0000_0000_0001_ff, 24'h1}, 0);
    queue_req(OP_WRITE, 7, 1, lla, {104'hff02_0000_0000_0000_0000_0001_ff, 24'haa}, 1);
    queue_req(OP_WRITE, 3, 1, ones, '0, 0);
    queue_req(OP_WRITE, 5, 0, 128'hfe80_0000_0000_0000_0000_0000_0000_0005, ones, 0);
    // link-local beats the lower index; longest byte run; no common byte
    queue_req(OP_RSOL,    0, 0, '0, '0, 0);
    queue_req(OP_NSOL,    0, 0, 128'h2001_0db8_0000_0000_0000_0000_0000_0099, '0, 0);
    queue_req(OP_NSOL,    0, 0, '0, '0, 0);
    queue_req(OP_LOOKUP,  0, 0, gua, '0, 0);
    queue_req(OP_IS_SELF, 0, 0, gua, '0, 0);
    queue_req(OP_IS_SELF, 0, 0, gua, '0, 1);
    // multicast scopes: accepted, rejected, rejected, widest
    queue_req(OP_IS_SELF, 0, 0, 128'hff02_0000_0000_0000_0000_0000_0000_0001, '0, 0);
    queue_req(OP_IS_SELF, 0, 0, 128'hff01_0000_0000_0000_0000_0000_0000_0001, '0, 0);
    queue_req(OP_IS_SELF, 0, 0, 128'hff00_0000_0000_0000_0000_0000_0000_0000, '0, 1);
    queue_req(OP_IS_SELF, 0, 0, ones, '0, 1);
    queue_req(OP_SOL,     0, 0, {104'hff02_0000_0000_0000_0000_0001_ff, 24'haa}, '0, 0);
    queue_req(OP_LOOKUP,  0, 0, ones, '0, 1);
    // duplicate address: lowest index wins
    queue_req(OP_WRITE,  0, 1, lla, ones, 0);
    queue_req(OP_LOOKUP, 0, 0, lla, '0, 0);
    queue_req(OP_SPARE6, 7, 1, ones, ones, 1);
    queue_req(OP_SPARE7, 7, 1, ones, ones, 1);
    wait_quiet();

    set_loopback(1'b1);
    queue_req(OP_IS_SELF, 0, 0, '0, '0, 1);
    queue_req(OP_IS_SELF, 0, 0, 128'hff01_0000_0000_0000_0000_0000_0000_0001, '0, 0);
    wait_quiet();

    for (int p = 0; p < 5; p++) begin
      case (p)
        0: begin send_idle_pct = 0;  rsp_stall_pct = 0;  set_loopback(1'b0); end
        1: begin send_idle_pct = 74; rsp_stall_pct = 0;  set_loopback(1'b1); end
        2: begin send_idle_pct = 0;  rsp_stall_pct = 74; set_loopback(1'b0); end
        3: begin send_idle_pct = 19; rsp_stall_pct = 19; set_loopback(1'b1); end
        default: begin
          send_idle_pct = 0;
          rsp_stall_pct = 0;
          set_loopback(1'b0);
          hold_go = 1'b1;
        end
      endcase
      for (int n = 0; n < ITEMS_PHASE; n++) pending_reqs.push_back(random_request());
      wait_quiet();
    end

    if (errors == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule

`default_nettype wire
